@@ src/rain_triggered_motor_alarm_ctrl_macros.svh @@
// Assertion macros used by the checker file of the rain motor alarm controller
`ifndef RAIN_TRIGGERED_MOTOR_ALARM_CTRL_MACROS_SVH
`define RAIN_TRIGGERED_MOTOR_ALARM_CTRL_MACROS_SVH

// clocked assertion, switched off while reset is high
`define RTMA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that is also checked while reset is high
`define RTMA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/rtma_pkg.sv @@
// Types, constants and the tone table of the rain motor alarm controller
`default_nettype none

package rtma_pkg;

   localparam int unsigned NOTE_COUNT = 6;
   localparam int unsigned TONE_LEN   = 6;

   localparam int unsigned SAMPLE_W   = 10;
   localparam int unsigned TIMER_W    = 16;
   localparam int unsigned RUN_W      = 20;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned NOTE_W     = 3;
   localparam int unsigned FREQ_W     = 10;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 32;

   localparam logic [NOTE_W-1:0] LAST_NOTE = NOTE_W'(NOTE_COUNT - 1);

   localparam logic [SAMPLE_W-1:0] LIGHT_THRESHOLD_RST   = 10'd500;
   localparam logic [SAMPLE_W-1:0] RAIN_THRESHOLD_RST    = 10'd500;
   localparam logic [RUN_W-1:0]    MOTOR_MAX_MS_RST      = 20'd10000;
   localparam logic [COUNT_W-1:0]  REV_LIMIT_RST         = 8'd10;
   localparam logic [TIMER_W-1:0]  REV_PERIOD_MS_RST     = 16'd1000;
   localparam logic [TIMER_W-1:0]  NOTE_PERIOD_MS_RST    = 16'd2000;
   localparam logic [TIMER_W-1:0]  ALARM_DURATION_MS_RST = 16'd12000;
   localparam logic [COUNT_W-1:0]  MOTOR_DUTY_RST        = 8'd200;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LIGHT_THRESHOLD   = 3'd0,
      CSR_RAIN_THRESHOLD    = 3'd1,
      CSR_MOTOR_MAX_MS      = 3'd2,
      CSR_REV_LIMIT         = 3'd3,
      CSR_REV_PERIOD_MS     = 3'd4,
      CSR_NOTE_PERIOD_MS    = 3'd5,
      CSR_ALARM_DURATION_MS = 3'd6,
      CSR_MOTOR_DUTY        = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_STOP    = 2'd0,
      DIR_FORWARD = 2'd1,
      DIR_REVERSE = 2'd2,
      DIR_UNUSED  = 2'd3
   } motor_dir_type;

   // result fields in tdata order, highest bit first
   typedef struct packed {
      logic [4:0]        pad;
      logic [FREQ_W-1:0] alarm_freq_hz;
      logic              alarm_on;
      logic              rain_lamp;
      logic              night_lamp;
      logic              day_lamp;
      logic              motor_two_on;
      logic [COUNT_W-1:0] motor_one_pwm;
      motor_dir_type     motor_one_dir;
      logic              raining;
      logic              light_present;
   } rsp_data_type;

   // indexes past the end of the table play the last tone
   function automatic logic [FREQ_W-1:0] tone_hz(input logic [NOTE_W-1:0] idx);
      logic [FREQ_W-1:0] hz;
      case (idx)
         3'd0:    hz = 10'd200;
         3'd1:    hz = 10'd250;
         3'd2:    hz = 10'd300;
         3'd3:    hz = 10'd350;
         3'd4:    hz = 10'd400;
         default: hz = 10'd450;
      endcase
      return hz;
   endfunction

endpackage

`default_nettype wire

@@ src/rain_triggered_motor_alarm_ctrl.sv @@
// A result is valid in the cycle after its tick transaction is accepted.
// Throughput: one tick per cycle; the next tick is taken while the result register
// drains, so only a stalled rsp side holds req_tready low.
// Reset (synchronous, active high): registers back to their defaults, motor one
// stopped and set forward, alarm silent, all timers and counters cleared.
`default_nettype none

module rain_triggered_motor_alarm_ctrl
   import rtma_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tdata: light_sample [9:0], rain_sample [19:10], zero fill [23:20]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: light_present, raining, motor_one_dir[2], motor_one_pwm[8],
   // motor_two_on, day_lamp, night_lamp, rain_lamp, alarm_on, alarm_freq_hz[10]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [SAMPLE_W-1:0] light_threshold_ff;
   logic [SAMPLE_W-1:0] rain_threshold_ff;
   logic [RUN_W-1:0]    motor_max_ms_ff;
   logic [COUNT_W-1:0]  rev_limit_ff;
   logic [TIMER_W-1:0]  rev_period_ms_ff;
   logic [TIMER_W-1:0]  note_period_ms_ff;
   logic [TIMER_W-1:0]  alarm_duration_ms_ff;
   logic [COUNT_W-1:0]  motor_duty_ff;

   // controller state
   logic               prev_rain_ff,     prev_rain_in;
   logic               motor_running_ff, motor_running_in;
   logic               motor_forward_ff, motor_forward_in;
   logic [COUNT_W-1:0] rev_count_ff,     rev_count_in;
   logic [TIMER_W-1:0] rev_timer_ff,     rev_timer_in;
   logic [RUN_W-1:0]   run_timer_ff,     run_timer_in;
   logic               alarm_active_ff,  alarm_active_in;
   logic [NOTE_W-1:0]  note_index_ff,    note_index_in;
   logic [TIMER_W-1:0] note_timer_ff,    note_timer_in;
   logic [TIMER_W-1:0] alarm_timer_ff,   alarm_timer_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff,  rsp_data_in;

   logic               req_fire;
   logic [SAMPLE_W-1:0] light_sample;
   logic [SAMPLE_W-1:0] rain_sample;
   logic               light;
   logic               rain;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_fire     = req_tvalid && req_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

   assign light_sample = req_tdata[SAMPLE_W-1:0];
   assign rain_sample  = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
   assign light        = light_sample < light_threshold_ff;
   assign rain         = rain_sample > rain_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_threshold_ff   <= LIGHT_THRESHOLD_RST;
         rain_threshold_ff    <= RAIN_THRESHOLD_RST;
         motor_max_ms_ff      <= MOTOR_MAX_MS_RST;
         rev_limit_ff         <= REV_LIMIT_RST;
         rev_period_ms_ff     <= REV_PERIOD_MS_RST;
         note_period_ms_ff    <= NOTE_PERIOD_MS_RST;
         alarm_duration_ms_ff <= ALARM_DURATION_MS_RST;
         motor_duty_ff        <= MOTOR_DUTY_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_LIGHT_THRESHOLD:   light_threshold_ff   <= csr_wdata[SAMPLE_W-1:0];
            CSR_RAIN_THRESHOLD:    rain_threshold_ff    <= csr_wdata[SAMPLE_W-1:0];
            CSR_MOTOR_MAX_MS:      motor_max_ms_ff      <= csr_wdata[RUN_W-1:0];
            CSR_REV_LIMIT:         rev_limit_ff         <= csr_wdata[COUNT_W-1:0];
            CSR_REV_PERIOD_MS:     rev_period_ms_ff     <= csr_wdata[TIMER_W-1:0];
            CSR_NOTE_PERIOD_MS:    note_period_ms_ff    <= csr_wdata[TIMER_W-1:0];
            CSR_ALARM_DURATION_MS: alarm_duration_ms_ff <= csr_wdata[TIMER_W-1:0];
            CSR_MOTOR_DUTY:        motor_duty_ff        <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // tick update: timers advance first, then edge handling, then period checks
   always_comb begin
      prev_rain_in     = rain;
      motor_running_in = motor_running_ff;
      motor_forward_in = motor_forward_ff;
      rev_count_in     = rev_count_ff;
      rev_timer_in     = rev_timer_ff;
      run_timer_in     = run_timer_ff;
      alarm_active_in  = alarm_active_ff;
      note_index_in    = note_index_ff;
      note_timer_in    = note_timer_ff;
      alarm_timer_in   = alarm_timer_ff;

      if (alarm_active_ff) begin
         if (note_timer_ff != '1)  note_timer_in  = note_timer_ff + 1'b1;
         if (alarm_timer_ff != '1) alarm_timer_in = alarm_timer_ff + 1'b1;
      end
      if (motor_running_ff) begin
         if (rev_timer_ff != '1) rev_timer_in = rev_timer_ff + 1'b1;
         if (run_timer_ff != '1) run_timer_in = run_timer_ff + 1'b1;
      end

      if (rain && !prev_rain_ff) begin
         alarm_active_in  = 1'b1;
         note_index_in    = '0;
         note_timer_in    = '0;
         alarm_timer_in   = '0;
         motor_running_in = 1'b1;
         motor_forward_in = 1'b1;
         rev_count_in     = '0;
         rev_timer_in     = '0;
         run_timer_in     = '0;
      end else if (!rain && prev_rain_ff) begin
         motor_running_in = 1'b1;
         motor_forward_in = 1'b0;
         rev_count_in     = '0;
         rev_timer_in     = '0;
         run_timer_in     = '0;
      end

      if (alarm_active_in) begin
         if (note_timer_in >= note_period_ms_ff) begin
            if (note_index_in < LAST_NOTE) note_index_in = note_index_in + 1'b1;
            note_timer_in = '0;
         end
         if (alarm_timer_in >= alarm_duration_ms_ff) alarm_active_in = 1'b0;
      end

      if (motor_running_in) begin
         if (rev_timer_in >= rev_period_ms_ff) begin
            if (rev_count_in != '1) rev_count_in = rev_count_in + 1'b1;
            rev_timer_in = '0;
         end
         if (run_timer_in >= motor_max_ms_ff || rev_count_in >= rev_limit_ff) begin
            motor_running_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_data_in               = '0;
      rsp_data_in.light_present = light;
      rsp_data_in.raining       = rain;
      rsp_data_in.motor_one_dir = !motor_running_in ? DIR_STOP :
                                  (motor_forward_in ? DIR_FORWARD : DIR_REVERSE);
      rsp_data_in.motor_one_pwm = motor_running_in ? motor_duty_ff : '0;
      rsp_data_in.motor_two_on  = rain;
      rsp_data_in.day_lamp      = light;
      rsp_data_in.night_lamp    = !light;
      rsp_data_in.rain_lamp     = rain;
      rsp_data_in.alarm_on      = alarm_active_in;
      rsp_data_in.alarm_freq_hz = alarm_active_in ? tone_hz(note_index_in) : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_rain_ff     <= 1'b0;
         motor_running_ff <= 1'b0;
         motor_forward_ff <= 1'b1;
         rev_count_ff     <= '0;
         rev_timer_ff     <= '0;
         run_timer_ff     <= '0;
         alarm_active_ff  <= 1'b0;
         note_index_ff    <= '0;
         note_timer_ff    <= '0;
         alarm_timer_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            prev_rain_ff     <= prev_rain_in;
            motor_running_ff <= motor_running_in;
            motor_forward_ff <= motor_forward_in;
            rev_count_ff     <= rev_count_in;
            rev_timer_ff     <= rev_timer_in;
            run_timer_ff     <= run_timer_in;
            alarm_active_ff  <= alarm_active_in;
            note_index_ff    <= note_index_in;
            note_timer_ff    <= note_timer_in;
            alarm_timer_ff   <= alarm_timer_in;
         end
      end
   end

   // result payload, loaded on each accepted tick
   always_ff @(posedge clock) begin
      if (req_fire) rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ src/rtma_checker.sv @@
// Port-level checks for the rain motor alarm controller, bound to the top level
`default_nettype none
`include "rain_triggered_motor_alarm_ctrl_macros.svh"

module rtma_checker
   import rtma_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready
);

   rsp_data_type rsp;

   assign rsp = rsp_tdata;

   // a stalled result transaction keeps its payload
   `RTMA_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp payload changed while stalled")

   // with the result register empty the block must take a tick
   `RTMA_ASSERT(a_ready_when_empty, !rsp_tvalid |-> req_tready, "req_tready low with empty result register")

   // lamps and motor two follow the thresholded flags
   `RTMA_ASSERT(a_flags_consistent, rsp_tvalid |-> rsp.night_lamp != rsp.day_lamp && rsp.day_lamp == rsp.light_present && rsp.motor_two_on == rsp.raining && rsp.rain_lamp == rsp.raining, "lamp or motor two out of step with flags")

   // alarm tone present exactly while the alarm sounds; motor code legal and pwm idle when stopped
   `RTMA_ASSERT(a_alarm_motor, rsp_tvalid |-> (rsp.alarm_on == (rsp.alarm_freq_hz != '0)) && rsp.motor_one_dir != DIR_UNUSED && (rsp.motor_one_dir != DIR_STOP || rsp.motor_one_pwm == '0), "alarm or motor one fields inconsistent")

   // no result straight out of reset
   `RTMA_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")

endmodule

bind rain_triggered_motor_alarm_ctrl rtma_checker u_rtma_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

@@ tb/sv/rain_triggered_motor_alarm_ctrl_tb.sv @@
// Self-checking testbench for the rain motor alarm controller: stream driver, monitor and predictor
module rain_triggered_motor_alarm_ctrl_tb;
   import rtma_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 300;
   localparam int HOLD_AFTER     = 400;
   localparam int RANDOM_PHASES  = 10;
   localparam logic [FREQ_W-1:0] NOTE_HZ [TONE_LEN] = '{200, 250, 300, 350, 400, 450};

   typedef struct packed {
      logic [SAMPLE_W-1:0] rain;
      logic [SAMPLE_W-1:0] light;
   } tick_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_RANDOM,
      RX_CHOPPY
   } rx_mode_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   rain_triggered_motor_alarm_ctrl u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   tick_type     pending_ticks[$];
   rsp_data_type predicted_outputs[$];
   int           mismatch_count = 0;

   // controller settings as seen by the predictor
   logic [SAMPLE_W-1:0] light_thr;
   logic [SAMPLE_W-1:0] rain_thr;
   logic [RUN_W-1:0]    motor_max;
   logic [COUNT_W-1:0]  rev_lim;
   logic [TIMER_W-1:0]  rev_period;
   logic [TIMER_W-1:0]  note_period;
   logic [TIMER_W-1:0]  alarm_dur;
   logic [COUNT_W-1:0]  duty;

   // controller state as seen by the predictor
   logic                was_wet;
   logic                motor_on;
   logic                motor_fwd;
   logic [COUNT_W-1:0]  revs;
   logic [TIMER_W-1:0]  rev_tmr;
   logic [RUN_W-1:0]    run_tmr;
   logic                alarm_live;
   logic [NOTE_W-1:0]   note_idx;
   logic [TIMER_W-1:0]  note_tmr;
   logic [TIMER_W-1:0]  alarm_tmr;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_data_type advance_controller(tick_type t);
      rsp_data_type r;
      logic         lit;
      logic         wet;
      lit = t.light < light_thr;
      wet = t.rain > rain_thr;
      if (alarm_live) begin
         if (note_tmr != '1) note_tmr = note_tmr + 1'b1;
         if (alarm_tmr != '1) alarm_tmr = alarm_tmr + 1'b1;
      end
      if (motor_on) begin
         if (rev_tmr != '1) rev_tmr = rev_tmr + 1'b1;
         if (run_tmr != '1) run_tmr = run_tmr + 1'b1;
      end
      if (wet && !was_wet) begin
         alarm_live = 1'b1;
         note_idx   = '0;
         note_tmr   = '0;
         alarm_tmr  = '0;
         motor_on   = 1'b1;
         motor_fwd  = 1'b1;
         revs       = '0;
         rev_tmr    = '0;
         run_tmr    = '0;
      end else if (!wet && was_wet) begin
         motor_on  = 1'b1;
         motor_fwd = 1'b0;
         revs      = '0;
         rev_tmr   = '0;
         run_tmr   = '0;
      end
      was_wet = wet;
      if (alarm_live) begin
         if (note_tmr >= note_period) begin
            if (note_idx < LAST_NOTE) note_idx = note_idx + 1'b1;
            note_tmr = '0;
         end
         if (alarm_tmr >= alarm_dur) alarm_live = 1'b0;
      end
      if (motor_on) begin
         if (rev_tmr >= rev_period) begin
            if (revs != '1) revs = revs + 1'b1;
            rev_tmr = '0;
         end
         if (run_tmr >= motor_max || revs >= rev_lim) motor_on = 1'b0;
      end
      r               = '0;
      r.light_present = lit;
      r.raining       = wet;
      r.motor_one_dir = !motor_on ? DIR_STOP : (motor_fwd ? DIR_FORWARD : DIR_REVERSE);
      r.motor_one_pwm = motor_on ? duty : '0;
      r.motor_two_on  = wet;
      r.day_lamp      = lit;
      r.night_lamp    = !lit;
      r.rain_lamp     = wet;
      r.alarm_on      = alarm_live;
      r.alarm_freq_hz = !alarm_live ? '0 :
                        NOTE_HZ[(note_idx < TONE_LEN) ? note_idx : TONE_LEN - 1];
      return r;
   endfunction

   task automatic load_settings(logic [CSR_DATA_W-1:0] s [8]);
      csr_index_type idx;
      for (int i = 0; i < 8; i++) begin
         idx = csr_index_type'(i);
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= idx;
         csr_wdata <= s[i];
         case (idx)
            CSR_LIGHT_THRESHOLD:   light_thr   = s[i][SAMPLE_W-1:0];
            CSR_RAIN_THRESHOLD:    rain_thr    = s[i][SAMPLE_W-1:0];
            CSR_MOTOR_MAX_MS:      motor_max   = s[i][RUN_W-1:0];
            CSR_REV_LIMIT:         rev_lim     = s[i][COUNT_W-1:0];
            CSR_REV_PERIOD_MS:     rev_period  = s[i][TIMER_W-1:0];
            CSR_NOTE_PERIOD_MS:    note_period = s[i][TIMER_W-1:0];
            CSR_ALARM_DURATION_MS: alarm_dur   = s[i][TIMER_W-1:0];
            CSR_MOTOR_DUTY:        duty        = s[i][COUNT_W-1:0];
            default: ;
         endcase
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_tick(int light, int rain);
      tick_type t;
      t.light = SAMPLE_W'(light);
      t.rain  = SAMPLE_W'(rain);
      pending_ticks.push_back(t);
   endtask

   // runs of dry and wet ticks around the rain threshold, with optional flicker
   task automatic queue_weather(int count, int min_run, int max_run, bit noisy);
      int       run_left;
      int       near;
      bit       wet;
      tick_type t;
      wet      = 1'($urandom_range(1, 0));
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            wet      = !wet;
            run_left = $urandom_range(max_run, min_run);
         end
         run_left--;
         if (noisy && $urandom_range(9, 0) == 0)
            t.rain = SAMPLE_W'($urandom);
         else if (wet)
            t.rain = (rain_thr == '1) ? '1 :
                     SAMPLE_W'($urandom_range(1023, int'(rain_thr) + 1));
         else
            t.rain = SAMPLE_W'($urandom_range(int'(rain_thr), 0));
         if ($urandom_range(3, 0) == 0) begin
            near = int'(light_thr) + int'($urandom_range(2, 0)) - 1;
            if (near < 0) near = 0;
            if (near > 1023) near = 1023;
            t.light = SAMPLE_W'(near);
         end else begin
            t.light = SAMPLE_W'($urandom);
         end
         pending_ticks.push_back(t);
      end
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || predicted_outputs.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] s [8];
      light_thr   = LIGHT_THRESHOLD_RST;
      rain_thr    = RAIN_THRESHOLD_RST;
      motor_max   = MOTOR_MAX_MS_RST;
      rev_lim     = REV_LIMIT_RST;
      rev_period  = REV_PERIOD_MS_RST;
      note_period = NOTE_PERIOD_MS_RST;
      alarm_dur   = ALARM_DURATION_MS_RST;
      duty        = MOTOR_DUTY_RST;
      was_wet     = 1'b0;
      motor_on    = 1'b0;
      motor_fwd   = 1'b1;
      revs        = '0;
      rev_tmr     = '0;
      run_tmr     = '0;
      alarm_live  = 1'b0;
      note_idx    = '0;
      note_tmr    = '0;
      alarm_tmr   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: sample extremes, threshold edges, rain start, stop and restart
      queue_tick(0, 0);
      queue_tick(1023, 1023);
      queue_tick(499, 501);
      queue_tick(500, 500);
      queue_tick(501, 501);
      queue_tick(1023, 0);
      wait_drained();

      // zero limits and periods: motor and alarm stop on the tick they start
      s = '{0, 0, 0, 0, 0, 0, 0, 255};
      load_settings(s);
      queue_tick(0, 1);
      queue_tick(1023, 0);
      queue_tick(0, 1023);
      queue_tick(512, 0);
      wait_drained();

      // note steps every tick, runs past the last note, then silences; revs stop motor
      s = '{500, 500, 20'hFFFFF, 3, 0, 0, 10, 128};
      load_settings(s);
      for (int i = 0; i < 13; i++) queue_tick(i * 77, 800);
      queue_tick(200, 100);
      queue_tick(200, 100);
      wait_drained();

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         case (k)
            0: s = '{1023, 1023, 20'hFFFFF, 255, 65535, 65535, 65535, 255};
            1: s = '{0, 0, 0, 0, 0, 0, 0, 0};
            2: s = '{$urandom_range(1023, 0), 500, 20'hFFFFF, 255, 1, 1, 200,
                     $urandom_range(255, 0)};
            default: s = '{$urandom_range(1023, 0), $urandom_range(900, 100),
                           ($urandom_range(4, 0) == 0) ? 20'hFFFFF : $urandom_range(60, 0),
                           $urandom_range(12, 0), $urandom_range(8, 1),
                           $urandom_range(10, 1), $urandom_range(80, 0),
                           $urandom_range(255, 0)};
         endcase
         load_settings(s);
         // long wet spell lets the revolution count saturate
         if (k == 2) queue_weather(300, 265, 280, 1'b0);
         else        queue_weather(90, 1, 40, 1'b1);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // driver: bursts of ticks separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid && req_tready) begin
            predicted_outputs.push_back(advance_controller(pending_ticks[0]));
            void'(pending_ticks.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_W'(pending_ticks[0]);
            if (burst_left == 0) burst_left = $urandom_range(60, 1);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(9, 0) < 4) ? 0 : $urandom_range(8, 1);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // monitor: checks each result transaction and drives its own stall pattern
   int          rsp_seen  = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          mode_left = 0;
   int          chop_cnt  = 0;
   rx_mode_type rx_mode   = RX_STEADY;

   always @(posedge clock) begin
      rsp_data_type exp_r;
      rsp_data_type act_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            act_r = rsp_data_type'(rsp_tdata);
            if (predicted_outputs.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               exp_r = predicted_outputs.pop_front();
               check_field("light_present", exp_r.light_present, act_r.light_present);
               check_field("raining", exp_r.raining, act_r.raining);
               check_field("motor_one_dir", exp_r.motor_one_dir, act_r.motor_one_dir);
               check_field("motor_one_pwm", exp_r.motor_one_pwm, act_r.motor_one_pwm);
               check_field("motor_two_on", exp_r.motor_two_on, act_r.motor_two_on);
               check_field("day_lamp", exp_r.day_lamp, act_r.day_lamp);
               check_field("night_lamp", exp_r.night_lamp, act_r.night_lamp);
               check_field("rain_lamp", exp_r.rain_lamp, act_r.rain_lamp);
               check_field("alarm_on", exp_r.alarm_on, act_r.alarm_on);
               check_field("alarm_freq_hz", exp_r.alarm_freq_hz, act_r.alarm_freq_hz);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
            // one long back-pressure spell so the input side fills and stalls
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(2, 0));
               mode_left = $urandom_range(200, 20);
            end
            mode_left--;
            chop_cnt++;
            case (rx_mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_RANDOM: rsp_tready <= ($urandom_range(3, 0) != 0);
               default:   rsp_tready <= (chop_cnt % 5 < 2);
            endcase
         end
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
